// ----- design/swad_pkg.sv -----
// Shared constants and helpers for the sliding-window anagram detector.
package swad_pkg;

    localparam int DEF_MAX_PATTERN = 64;
    localparam int DEF_ALPHABET    = 26;
    localparam int LETTER_W        = 5;

    // Item function codes
    localparam logic FUNC_PATTERN = 1'b0;
    localparam logic FUNC_TEXT    = 1'b1;

    // Address width for a storage of the given depth (at least one bit)
    function automatic int idx_w(input int depth);
        int w;
        w = (depth > 1) ? $clog2(depth) : 1;
        return w;
    endfunction

endpackage

// ----- design/sliding_window_anagram_detector.sv -----
// Top level of the sliding-window anagram detector.
//
//   channel | signals                                  | transfer
//   --------+------------------------------------------+---------------------
//   input   | in_valid, in_ready, func, letter,        | in_valid & in_ready
//           | start_req                                |
//   output  | out_valid, out_ready, window_match,      | out_valid & out_ready
//           | found, window_full                       |
//
// Flow: one transaction per cycle while out_ready stays high; an accepted
//   transaction passes the ring read, the count read, then the update into the
//   output register before its result is on the outputs. The count RAMs take one
//   read-modify-write per letter per cycle.
// Reset: rst_n clears all control state at once; per-letter valid bits stand
//   in for cleared counts, so there is no clearing pass.
// Stalls: out_ready low holds the result; up to two more transactions enter
//   behind it before in_ready drops.
module sliding_window_anagram_detector
    import swad_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int ALPHABET    = DEF_ALPHABET
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                func,
    input  logic [LETTER_W-1:0] letter,
    input  logic                start_req,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                window_match,
    output logic                found,
    output logic                window_full
);

    // Widths: counts up to MAX_PATTERN, ring index, letter address, unequal count
    localparam int CW  = $clog2(MAX_PATTERN + 1);
    localparam int RW  = idx_w(MAX_PATTERN);
    localparam int AW  = $clog2(ALPHABET);
    localparam int UW  = $clog2(ALPHABET + 1);
    localparam int PEW = 2 * CW;

    // Item as it travels down the pipeline
    typedef struct packed {
        logic                text;
        logic                start;
        logic [LETTER_W-1:0] letter;
        logic                add_ok;   // pattern letter is counted
        logic                empty;    // text item with empty pattern
        logic                leave;    // oldest window letter leaves
        logic                full;     // window full after this item
    } item_t;

    // ------------------------------------------------------------------
    // Handshake and pipeline occupancy
    // ------------------------------------------------------------------
    logic  s1_valid_reg, s1_valid_next;
    logic  s2_valid_reg, s2_valid_next;
    logic  out_valid_reg, out_valid_next;
    logic  out_free, s2_free, s1_load, s1_go, s2_go;

    assign out_free = !out_valid_reg || out_ready;
    assign s2_go    = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_go    = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;
    assign s1_load  = in_valid && in_ready;

    assign s1_valid_next  = s1_load ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
    assign s2_valid_next  = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_valid_reg);
    assign out_valid_next = s2_go ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // ------------------------------------------------------------------
    // Front end: pattern length, text fill and ring position advance at
    // accept time, since they depend on the inputs alone.
    // ------------------------------------------------------------------
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [RW-1:0] pos_reg, pos_next;
    item_t         s1_reg, s1_next;

    logic          in_text, in_letter_ok;
    logic [CW-1:0] len_base, fill_base, fill_after, pos_inc;
    logic [RW-1:0] pos_base;
    logic          ring_we_c;

    logic [0:0][RW-1:0]       ring_raddr;
    logic [0:0][LETTER_W-1:0] ring_rdata;
    logic [LETTER_W-1:0]      ring_rd;

    always_comb
    begin
        in_text      = (func == FUNC_TEXT);
        in_letter_ok = (32'(letter) < ALPHABET);
        len_base     = (!in_text && start_req) ? '0 : len_reg;
        fill_base    = start_req ? '0 : fill_reg;
        pos_base     = start_req ? '0 : pos_reg;
        pos_inc      = CW'(pos_base) + CW'(1);
        fill_after   = fill_base + CW'(fill_base < len_reg);

        len_next  = len_reg;
        fill_next = fill_reg;
        pos_next  = pos_reg;
        ring_we_c = 1'b0;

        s1_next.text   = in_text;
        s1_next.start  = start_req;
        s1_next.letter = letter;
        s1_next.add_ok = 1'b0;
        s1_next.empty  = 1'b0;
        s1_next.leave  = 1'b0;
        s1_next.full   = 1'b0;

        if (!in_text)
        begin
            // Count the letter while there is room; restart the text side
            s1_next.add_ok = in_letter_ok && (32'(len_base) < MAX_PATTERN);
            len_next       = len_base + CW'(s1_next.add_ok);
            fill_next      = '0;
            pos_next       = '0;
        end
        else if (len_reg == '0)
        begin
            s1_next.empty = 1'b1;
            fill_next     = fill_base;
            pos_next      = pos_base;
        end
        else
        begin
            // Read the leaving letter and store the entering one in one slot
            s1_next.leave = (fill_base >= len_reg);
            s1_next.full  = (fill_after >= len_reg);
            ring_we_c     = 1'b1;
            fill_next     = fill_after;
            pos_next      = (pos_inc >= len_reg) ? '0 : RW'(pos_inc);
        end
    end

    assign ring_raddr[0] = pos_base;
    assign ring_rd       = ring_rdata[0];

    swad_ram #(
        .WIDTH    (LETTER_W),
        .DEPTH    (MAX_PATTERN),
        .RD_PORTS (1)
    ) u_ring_ram (
        .clk   (clk),
        .we    (s1_load && ring_we_c),
        .waddr (pos_base),
        .wdata (letter),
        .re    (s1_load),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // ------------------------------------------------------------------
    // Count RAMs: pattern and entered counts share a word, left counts sit
    // in a second RAM, so each takes one write per cycle. The window count
    // of a letter is entered minus left, modulo 2^CW.
    // ------------------------------------------------------------------
    item_t               s2_reg;
    logic [LETTER_W-1:0] s2_leave_reg;

    logic [1:0][AW-1:0]  cnt_raddr;
    logic [1:0][PEW-1:0] pe_rdata;
    logic [1:0][CW-1:0]  x_rdata;

    logic                pe_we, x_we;
    logic [PEW-1:0]      pe_wdata;
    logic [CW-1:0]       x_wdata;
    logic [AW-1:0]       c_addr, l_addr;

    // Issue reads for the entering letter and the leaving letter
    assign cnt_raddr[0] = AW'(s1_reg.letter);
    assign cnt_raddr[1] = AW'(ring_rd);

    swad_ram #(
        .WIDTH    (PEW),
        .DEPTH    (ALPHABET),
        .RD_PORTS (2)
    ) u_pe_ram (
        .clk   (clk),
        .we    (pe_we),
        .waddr (c_addr),
        .wdata (pe_wdata),
        .re    (s1_go),
        .raddr (cnt_raddr),
        .rdata (pe_rdata)
    );

    swad_ram #(
        .WIDTH    (CW),
        .DEPTH    (ALPHABET),
        .RD_PORTS (2)
    ) u_x_ram (
        .clk   (clk),
        .we    (x_we),
        .waddr (l_addr),
        .wdata (x_wdata),
        .re    (s1_go),
        .raddr (cnt_raddr),
        .rdata (x_rdata)
    );

    // ------------------------------------------------------------------
    // Update stage: forward the last write, mask cleared entries, update
    // the unequal-letter count and the sticky flag, write back.
    // ------------------------------------------------------------------
    logic [ALPHABET-1:0] pat_valid_reg, pat_valid_next;
    logic [ALPHABET-1:0] e_valid_reg, e_valid_next;
    logic [ALPHABET-1:0] x_valid_reg, x_valid_next;
    logic [UW-1:0]       nz_reg, nz_next;
    logic [UW-1:0]       uneq_reg, uneq_next;
    logic                found_reg, found_next;

    logic                fwd_pe_en_reg, fwd_x_en_reg;
    logic [AW-1:0]       fwd_pe_addr_reg, fwd_x_addr_reg;
    logic [PEW-1:0]      fwd_pe_data_reg;
    logic [CW-1:0]       fwd_x_data_reg;

    logic                window_match_reg, found_out_reg, window_full_reg;
    logic                res_match, res_found, res_full;

    logic                c_ok, l_ok, pat_clr, txt_clr, same;
    logic [PEW-1:0]      pe_c, pe_l;
    logic [CW-1:0]       xr_c, xr_l;
    logic [CW-1:0]       p_c, p_l, e_c, e_l, x_c, x_l, w_c, w_l;
    logic                use_c, use_l;
    logic                inc_c, dec_c, inc_l, dec_l;
    logic [UW-1:0]       uneq_base, uneq_sum, nz_base;

    assign c_addr = AW'(s2_reg.letter);
    assign l_addr = AW'(s2_leave_reg);

    always_comb
    begin
        c_ok    = (32'(s2_reg.letter) < ALPHABET);
        l_ok    = (32'(s2_leave_reg) < ALPHABET);
        pat_clr = !s2_reg.text && s2_reg.start;
        txt_clr = s2_reg.text && s2_reg.start;

        // Forward the previous write; RAM reads return the older word
        pe_c = (fwd_pe_en_reg && fwd_pe_addr_reg == c_addr) ? fwd_pe_data_reg : pe_rdata[0];
        pe_l = (fwd_pe_en_reg && fwd_pe_addr_reg == l_addr) ? fwd_pe_data_reg : pe_rdata[1];
        xr_c = (fwd_x_en_reg && fwd_x_addr_reg == c_addr) ? fwd_x_data_reg : x_rdata[0];
        xr_l = (fwd_x_en_reg && fwd_x_addr_reg == l_addr) ? fwd_x_data_reg : x_rdata[1];

        // Entries not written since their last clear read as zero
        p_c = (c_ok && pat_valid_reg[c_addr] && !pat_clr) ? pe_c[PEW-1:CW] : '0;
        p_l = (l_ok && pat_valid_reg[l_addr]) ? pe_l[PEW-1:CW] : '0;
        e_c = (c_ok && e_valid_reg[c_addr] && !txt_clr) ? pe_c[CW-1:0] : '0;
        e_l = (l_ok && e_valid_reg[l_addr] && !txt_clr) ? pe_l[CW-1:0] : '0;
        x_c = (c_ok && x_valid_reg[c_addr] && !txt_clr) ? xr_c : '0;
        x_l = (l_ok && x_valid_reg[l_addr] && !txt_clr) ? xr_l : '0;
        w_c = e_c - x_c;
        w_l = e_l - x_l;

        use_c = c_ok;
        use_l = s2_reg.leave && l_ok;
        same  = use_c && use_l && (c_addr == l_addr);

        // Each touched letter may join or leave the set of unequal letters
        inc_l = use_l && !same && (w_l == p_l) && ((w_l - CW'(1)) != p_l);
        dec_l = use_l && !same && (w_l != p_l) && ((w_l - CW'(1)) == p_l);
        inc_c = use_c && !same && (w_c == p_c) && ((w_c + CW'(1)) != p_c);
        dec_c = use_c && !same && (w_c != p_c) && ((w_c + CW'(1)) == p_c);

        uneq_base = s2_reg.start ? nz_reg : uneq_reg;
        uneq_sum  = uneq_base + UW'(inc_l) + UW'(inc_c) - UW'(dec_l) - UW'(dec_c);
        nz_base   = pat_clr ? '0 : nz_reg;

        pat_valid_next = pat_valid_reg;
        e_valid_next   = e_valid_reg;
        x_valid_next   = x_valid_reg;
        nz_next        = nz_reg;
        uneq_next      = uneq_reg;
        found_next     = found_reg;
        pe_we          = 1'b0;
        pe_wdata       = {p_c, e_c + CW'(1)};
        x_we           = 1'b0;
        x_wdata        = x_l + CW'(1);
        res_match      = 1'b0;
        res_found      = 1'b0;
        res_full       = 1'b0;

        if (s2_go)
        begin
            if (!s2_reg.text)
            begin
                // Pattern letter: count it, then restart the text side
                if (pat_clr)
                begin
                    pat_valid_next = '0;
                end
                nz_next = nz_base;
                if (s2_reg.add_ok)
                begin
                    pe_we                  = 1'b1;
                    pe_wdata               = {p_c + CW'(1), CW'(0)};
                    pat_valid_next[c_addr] = 1'b1;
                    nz_next                = nz_base + UW'(p_c == '0);
                end
                e_valid_next = '0;
                x_valid_next = '0;
                uneq_next    = nz_next;
                found_next   = 1'b0;
            end
            else
            begin
                if (txt_clr)
                begin
                    e_valid_next = '0;
                    x_valid_next = '0;
                end
                if (s2_reg.empty)
                begin
                    // Empty pattern matches every window
                    uneq_next  = uneq_base;
                    res_match  = 1'b1;
                    res_full   = 1'b1;
                    found_next = 1'b1;
                end
                else
                begin
                    if (use_c)
                    begin
                        pe_we                = 1'b1;
                        e_valid_next[c_addr] = 1'b1;
                    end
                    if (use_l)
                    begin
                        x_we                 = 1'b1;
                        x_valid_next[l_addr] = 1'b1;
                    end
                    uneq_next  = uneq_sum;
                    res_full   = s2_reg.full;
                    res_match  = s2_reg.full && (uneq_sum == '0);
                    found_next = (found_reg && !txt_clr) || res_match;
                end
                res_found = found_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            len_reg       <= '0;
            fill_reg      <= '0;
            pos_reg       <= '0;
            pat_valid_reg <= '0;
            e_valid_reg   <= '0;
            x_valid_reg   <= '0;
            nz_reg        <= '0;
            uneq_reg      <= '0;
            found_reg     <= 1'b0;
            fwd_pe_en_reg <= 1'b0;
            fwd_x_en_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_load)
            begin
                len_reg  <= len_next;
                fill_reg <= fill_next;
                pos_reg  <= pos_next;
            end
            pat_valid_reg <= pat_valid_next;
            e_valid_reg   <= e_valid_next;
            x_valid_reg   <= x_valid_next;
            nz_reg        <= nz_next;
            uneq_reg      <= uneq_next;
            found_reg     <= found_next;
            if (pe_we)
            begin
                fwd_pe_en_reg <= 1'b1;
            end
            if (x_we)
            begin
                fwd_x_en_reg <= 1'b1;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg <= s1_next;
        end
        if (s1_go)
        begin
            s2_reg       <= s1_reg;
            s2_leave_reg <= ring_rd;
        end
        if (pe_we)
        begin
            fwd_pe_addr_reg <= c_addr;
            fwd_pe_data_reg <= pe_wdata;
        end
        if (x_we)
        begin
            fwd_x_addr_reg <= l_addr;
            fwd_x_data_reg <= x_wdata;
        end
        if (s2_go)
        begin
            window_match_reg <= res_match;
            found_out_reg    <= res_found;
            window_full_reg  <= res_full;
        end
    end

    assign out_valid    = out_valid_reg;
    assign window_match = window_match_reg;
    assign found        = found_out_reg;
    assign window_full  = window_full_reg;

endmodule

// ----- design/swad_ram.sv -----
// Generic synchronous RAM: one write port, registered read-first read ports.
module swad_ram
    import swad_pkg::*;
#(
    parameter int WIDTH    = LETTER_W,
    parameter int DEPTH    = DEF_ALPHABET,
    parameter int RD_PORTS = 2
) (
    input  logic                               clk,
    input  logic                               we,
    input  logic [idx_w(DEPTH)-1:0]            waddr,
    input  logic [WIDTH-1:0]                   wdata,
    input  logic                               re,
    input  logic [RD_PORTS-1:0][idx_w(DEPTH)-1:0] raddr,
    output logic [RD_PORTS-1:0][WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0]               mem [DEPTH];
    logic [RD_PORTS-1:0][WIDTH-1:0] rdata_reg;

    // Read returns the old word when the same entry is written in that cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            for (int p = 0; p < RD_PORTS; p++)
            begin
                rdata_reg[p] <= mem[raddr[p]];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- dv/sliding_window_anagram_detector_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the sliding-window anagram detector.
module sliding_window_anagram_detector_test;
    import swad_pkg::*;

    localparam int ALPHA        = DEF_ALPHABET;
    localparam int RING_DEPTH   = DEF_MAX_PATTERN;
    localparam int ITEM_TARGET  = 1950;
    localparam int MAX_GAP      = 8;
    localparam int DRAIN_CYCLES = 12;
    // Hard limit for the slowest correct run: ~2.5k transactions, each with an idle
    // gap of up to MAX_GAP on either side, plus the pipeline.
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic window_match;
        logic found;
        logic window_full;
    } anagram_flags_t;

    // DUT interface; every input starts at a known value
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic                func      = FUNC_PATTERN;
    logic [LETTER_W-1:0] letter    = '0;
    logic                start_req = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                window_match;
    logic                found;
    logic                window_full;

    // Anagram predictor state
    logic [6:0] pat_cnt [ALPHA];
    logic [6:0] win_cnt [ALPHA];
    logic [6:0] pat_len;
    logic [4:0] recent_letters [RING_DEPTH];
    logic [5:0] oldest_slot;
    logic [6:0] text_seen;
    logic [4:0] unequal_count;
    logic       seen_match;

    anagram_flags_t pending_flags [$];

    int  error_count = 0;
    int  items_sent  = 0;
    int  cycle_count = 0;
    int  stall_left  = 0;
    // When set, both sides run back to back with no idle cycles
    logic calm = 1'b0;

    sliding_window_anagram_detector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .letter       (letter),
        .start_req    (start_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .window_match (window_match),
        .found        (found),
        .window_full  (window_full)
    );

    always #1 clk = ~clk;

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sliding_window_anagram_detector_test: errors");
            $finish;
        end
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int draw_gap();
        return calm ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Empty the window, drop the found flag and recount differing letters.
    function automatic void clear_window();
        unequal_count = '0;
        for (int c = 0; c < ALPHA; c++)
        begin
            win_cnt[c] = '0;
            if (pat_cnt[c] != 0)
                unequal_count++;
        end
        oldest_slot = '0;
        text_seen   = '0;
        seen_match  = 1'b0;
    endfunction

    // Add or remove one letter from the window, tracking the unequal count.
    function automatic void window_bump(input logic [4:0] ch, input logic up);
        logic differed;
        if (ch >= ALPHA)
            return;
        differed = win_cnt[ch] != pat_cnt[ch];
        if (up)
            win_cnt[ch] = win_cnt[ch] + 7'd1;
        else if (win_cnt[ch] != 0)
            win_cnt[ch] = win_cnt[ch] - 7'd1;
        if (differed && win_cnt[ch] == pat_cnt[ch])
            unequal_count--;
        else if (!differed && win_cnt[ch] != pat_cnt[ch])
            unequal_count++;
    endfunction

    // Advance the predictor by one transaction and return the flags it yields.
    function automatic anagram_flags_t step_anagram(input logic kind,
                                                    input logic [4:0] ch,
                                                    input logic fresh);
        anagram_flags_t r;
        int slot;
        r = '0;
        if (kind == FUNC_PATTERN)
        begin
            if (fresh)
            begin
                for (int c = 0; c < ALPHA; c++)
                    pat_cnt[c] = '0;
                pat_len = '0;
            end
            // Letters past the pattern capacity or outside the alphabet drop out
            if (ch < ALPHA && pat_len < RING_DEPTH)
            begin
                pat_cnt[ch] = pat_cnt[ch] + 7'd1;
                pat_len     = pat_len + 7'd1;
            end
            clear_window();
            return r;
        end
        if (fresh)
            clear_window();
        if (pat_len == 0)
        begin
            // Empty pattern matches everything
            r.window_match = 1'b1;
            r.window_full  = 1'b1;
        end
        else
        begin
            slot = oldest_slot;
            if (text_seen >= pat_len)
                window_bump(recent_letters[slot], 1'b0);
            window_bump(ch, 1'b1);
            recent_letters[slot] = ch;
            oldest_slot = (slot + 1 >= pat_len) ? 6'd0 : 6'(slot + 1);
            if (text_seen < pat_len)
                text_seen = text_seen + 7'd1;
            r.window_full  = text_seen >= pat_len;
            r.window_match = r.window_full && unequal_count == 0;
        end
        if (r.window_match)
            seen_match = 1'b1;
        r.found = seen_match;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one transaction after a random idle gap; hold until accepted.
    task automatic send_item(input logic kind, input logic [4:0] ch, input logic fresh);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= kind;
        letter    <= ch;
        start_req <= fresh;
        do
            @(posedge clk);
        while (!in_ready);
        pending_flags.push_back(step_anagram(kind, ch, fresh));
        items_sent++;
    endtask

    // ------------------------------------------------------------------
    // Output side: stall at random and check every result transaction
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic want, input logic got);
        if (want !== got)
            report_mismatch($sformatf("%s expected %b got %b", name, want, got));
    endtask

    always @(posedge clk)
    begin
        anagram_flags_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_flags.size() == 0)
                    report_mismatch("result with no transaction pending");
                else
                begin
                    want = pending_flags.pop_front();
                    check_field("window_match", want.window_match, window_match);
                    check_field("found", want.found, found);
                    check_field("window_full", want.window_full, window_full);
                end
                stall_left = draw_gap();
            end
            else if (stall_left > 0)
                stall_left--;
        end
        out_ready <= rst_n && stall_left == 0;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Load a pattern of the given length from a pool of span letters, then
    // stream text drawn from the same pool with planted permutations,
    // restarts and occasional noise.
    task automatic run_search(input int plen, input int span);
        logic [4:0] word [$];
        logic [4:0] shuffled [$];
        logic [4:0] tmp;
        int base;
        int text_len;
        int plant_pct;
        int roll;
        int j;
        base = $urandom_range(0, ALPHA - span);
        calm = ($urandom_range(0, 3) == 0);
        if (plen == 0)
            // A restart carrying an out-of-range letter leaves the pattern empty
            send_item(FUNC_PATTERN, 5'(ALPHA + $urandom_range(0, 31 - ALPHA)), 1'b1);
        for (int k = 0; k < plen; k++)
        begin
            tmp = 5'(base + $urandom_range(0, span - 1));
            if (word.size() < RING_DEPTH)
                word.push_back(tmp);
            send_item(FUNC_PATTERN, tmp, k == 0);
        end
        text_len  = (plen > 8) ? $urandom_range(70, 140) : $urandom_range(plen + 2, 30);
        plant_pct = (plen > 8) ? 1 : 12;
        for (int k = 0; k < text_len; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < plant_pct && word.size() != 0)
            begin
                // Plant a shuffled copy of the pattern
                shuffled = word;
                for (int i = shuffled.size() - 1; i > 0; i--)
                begin
                    j = $urandom_range(0, i);
                    tmp = shuffled[i];
                    shuffled[i] = shuffled[j];
                    shuffled[j] = tmp;
                end
                foreach (shuffled[i])
                    send_item(FUNC_TEXT, shuffled[i], 1'b0);
            end
            else if (roll < 15)
                send_item(FUNC_TEXT, 5'(base + $urandom_range(0, span - 1)), 1'b1);
            else if (roll < 18)
                send_item(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                          1'($urandom_range(0, 1)));
            else
                send_item(FUNC_TEXT, 5'(base + $urandom_range(0, span - 1)), 1'b0);
        end
    endtask

    // Text with no pattern loaded, and a pattern emptied by a restart.
    task automatic test_empty_pattern();
        send_item(FUNC_TEXT, 5'd0, 1'b0);
        send_item(FUNC_TEXT, 5'd25, 1'b1);
        send_item(FUNC_TEXT, 5'd31, 1'b0);
        send_item(FUNC_PATTERN, 5'd31, 1'b1);
        send_item(FUNC_TEXT, 5'd7, 1'b0);
    endtask

    // Pattern "abz": matches, sticky found, text restart, letters outside
    // the alphabet, and a pattern transaction that clears the text side.
    task automatic test_directed_search();
        send_item(FUNC_PATTERN, 5'd0, 1'b1);
        send_item(FUNC_PATTERN, 5'd1, 1'b0);
        send_item(FUNC_PATTERN, 5'd25, 1'b0);
        send_item(FUNC_TEXT, 5'd25, 1'b0);
        send_item(FUNC_TEXT, 5'd0, 1'b0);
        send_item(FUNC_TEXT, 5'd1, 1'b0);
        send_item(FUNC_TEXT, 5'd2, 1'b0);
        send_item(FUNC_TEXT, 5'd0, 1'b0);
        send_item(FUNC_TEXT, 5'd1, 1'b1);
        send_item(FUNC_TEXT, 5'd26, 1'b0);
        send_item(FUNC_TEXT, 5'd0, 1'b0);
        send_item(FUNC_TEXT, 5'd25, 1'b0);
        send_item(FUNC_TEXT, 5'd1, 1'b0);
        // Out-of-range pattern letter adds nothing but resets the window
        send_item(FUNC_PATTERN, 5'd31, 1'b0);
        send_item(FUNC_TEXT, 5'd1, 1'b0);
        send_item(FUNC_TEXT, 5'd0, 1'b0);
        send_item(FUNC_TEXT, 5'd25, 1'b0);
        send_item(FUNC_TEXT, 5'd16, 1'b0);
    endtask

    // Pattern longer than the capacity: letters past it are dropped.
    task automatic test_pattern_overflow();
        run_search(RING_DEPTH + 2, 3);
    endtask

    // Random patterns and text, mostly short, a few empty or at capacity.
    task automatic test_random_search();
        int pick;
        int plen;
        int span;
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                plen = 0;
            else if (pick == 1)
                plen = $urandom_range(RING_DEPTH - 4, RING_DEPTH + 6);
            else
                plen = $urandom_range(1, 6);
            span = ($urandom_range(0, 3) == 0) ? $urandom_range(2, ALPHA)
                                               : $urandom_range(2, 4);
            run_search(plen, span);
        end
    endtask

    initial
    begin
        for (int c = 0; c < ALPHA; c++)
        begin
            pat_cnt[c] = '0;
            win_cnt[c] = '0;
        end
        for (int i = 0; i < RING_DEPTH; i++)
            recent_letters[i] = '0;
        pat_len       = '0;
        oldest_slot   = '0;
        text_seen     = '0;
        unequal_count = '0;
        seen_match    = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pattern();
        test_directed_search();
        test_pattern_overflow();
        test_random_search();

        // Drop valid, drain the pipeline, then give stray results a chance
        in_valid <= 1'b0;
        calm = 1'b0;
        while (pending_flags.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("sliding_window_anagram_detector_test: clean");
        else
            $display("sliding_window_anagram_detector_test: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/swad_pkg.sv
design/swad_ram.sv
design/sliding_window_anagram_detector.sv
dv/sliding_window_anagram_detector_test.sv
